/* src/salc_pkg.sv */
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and constants of the set-associative LRU cache model.
// ----------------------------------------------------------------------------
package salc_pkg;

	// access kinds
	localparam logic [1:0] KIND_LOAD   = 2'd0;
	localparam logic [1:0] KIND_STORE  = 2'd1;
	localparam logic [1:0] KIND_MODIFY = 2'd2;
	localparam logic [1:0] KIND_NONE   = 2'd3;

	// register indexes (byte address bits [3:2])
	localparam logic [1:0] REG_SET_BITS    = 2'd0;
	localparam logic [1:0] REG_OFFSET_BITS = 2'd1;
	localparam logic [1:0] REG_WAYS        = 2'd2;

	localparam int SET_INDEX_W = 6;
	localparam int CNT_W       = 32;
	localparam int PADDR_W     = 4;
	localparam int PDATA_W     = 32;

	// controller to datapath commands
	typedef struct packed {
		logic accept;   // latch transaction, read the set row
		logic resolve;  // look up, update row and counters, load result
		logic second;   // load the forced hit of a modify
	} salc_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_free;
		logic is_modify;
		logic no_access;
	} salc_stat_t;

endpackage

/* src/salc_ctrl.sv */
// ----------------------------------------------------------------------------
// salc_ctrl
// Sequencer: accept, resolve one or two accesses, return to idle.
// ----------------------------------------------------------------------------
module salc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  salc_pkg::salc_stat_t stat,
	output salc_pkg::salc_cmd_t  cmd
);
	import salc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_SECOND
	} state_t;

	state_t state_q;

	// command decode
	always_comb begin
		cmd         = '0;
		in_ready    = (state_q == ST_IDLE);
		cmd.accept  = (state_q == ST_IDLE) && in_valid;
		cmd.resolve = (state_q == ST_LOOK) && stat.out_free;
		cmd.second  = (state_q == ST_SECOND) && stat.out_free;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && !stat.no_access)
						state_q <= ST_LOOK;
				end
				ST_LOOK: begin
					if (stat.out_free)
						state_q <= stat.is_modify ? ST_SECOND : ST_IDLE;
				end
				ST_SECOND: begin
					if (stat.out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* src/salc_dp.sv */
// ----------------------------------------------------------------------------
// salc_dp
// Datapath: address split, set row memory, LRU update, counters, result reg.
// ----------------------------------------------------------------------------
module salc_dp #(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8,
	parameter int ADDR_WIDTH   = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  salc_pkg::salc_cmd_t             cmd,
	output salc_pkg::salc_stat_t            stat,
	input  logic [2:0]                      set_bits,
	input  logic [4:0]                      offset_bits,
	input  logic [3:0]                      ways_in_use,
	input  logic [1:0]                      kind,
	input  logic [ADDR_WIDTH-1:0]           address,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            hit,
	output logic                            evicted,
	output logic [salc_pkg::SET_INDEX_W-1:0] set_index,
	output logic [salc_pkg::CNT_W-1:0]      hit_total,
	output logic [salc_pkg::CNT_W-1:0]      miss_total,
	output logic [salc_pkg::CNT_W-1:0]      eviction_total,
	output logic                            last
);
	import salc_pkg::*;

	localparam int SW       = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int NUM_SETS = 1 << MAX_SET_BITS;
	localparam int RW       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int CW       = $clog2(MAX_WAYS + 1);

	// set row memory: tags, ranks and fill count of one set per entry
	logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_mem  [NUM_SETS];
	logic [MAX_WAYS-1:0][RW-1:0]         rank_mem [NUM_SETS];
	logic [CW-1:0]                       fill_mem [NUM_SETS];
	logic [NUM_SETS-1:0]                 set_valid_q;

	logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] rd_tags_q;
	logic [MAX_WAYS-1:0][RW-1:0]         rd_ranks_q;
	logic [CW-1:0]                       rd_fill_q;

	logic [SW-1:0]         set_s1;
	logic [ADDR_WIDTH-1:0] tag_s1;
	logic                  modify_s1;

	logic [CNT_W-1:0] hit_cnt_q, miss_cnt_q, evict_cnt_q;
	logic             out_valid_q;

	// address split
	logic [3:0]                 s_eff;
	logic [5:0]                 sb_sum;
	logic [ADDR_WIDTH-1:0]      shifted;
	logic [ADDR_WIDTH+SW-1:0]   shifted_ext;
	logic [SW-1:0]              set_d;
	logic [ADDR_WIDTH-1:0]      tag_d;

	always_comb begin
		s_eff       = (int'(set_bits) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : 4'(set_bits);
		sb_sum      = 6'(s_eff) + 6'(offset_bits);
		shifted     = (int'(offset_bits) >= ADDR_WIDTH) ? '0 : (address >> offset_bits);
		shifted_ext = {{SW{1'b0}}, shifted};
		for (int i = 0; i < SW; i++)
			set_d[i] = (i < int'(s_eff)) ? shifted_ext[i] : 1'b0;
		tag_d = (int'(sb_sum) >= ADDR_WIDTH) ? '0 : (address >> sb_sum);
	end

	// lookup and LRU update on the row read at accept
	logic [CW-1:0]                       filled;
	logic [CW-1:0]                       ways_eff;
	logic                                look_hit, full;
	logic [RW-1:0]                       hit_way, evict_way, victim, ref_rank;
	logic [MAX_WAYS-1:0][RW-1:0]         new_ranks;
	logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] new_tags;
	logic [CW-1:0]                       new_fill;

	always_comb begin
		filled = set_valid_q[set_s1] ? rd_fill_q : '0;
		if (ways_in_use == 4'd0)
			ways_eff = CW'(1);
		else if (int'(ways_in_use) > MAX_WAYS)
			ways_eff = CW'(MAX_WAYS);
		else
			ways_eff = CW'(ways_in_use);
		full = (filled >= ways_eff);

		look_hit  = 1'b0;
		hit_way   = '0;
		evict_way = '0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (w < int'(filled)) begin
				if (!look_hit && rd_tags_q[w] == tag_s1) begin
					look_hit = 1'b1;
					hit_way  = RW'(w);
				end
				if (int'(rd_ranks_q[w]) == int'(filled) - 1)
					evict_way = RW'(w);
			end
		end

		ref_rank = look_hit ? rd_ranks_q[hit_way] : RW'(filled - CW'(1));
		if (look_hit)
			victim = hit_way;
		else if (full)
			victim = evict_way;
		else
			victim = RW'(filled);

		new_tags = rd_tags_q;
		if (!look_hit)
			new_tags[victim] = tag_s1;
		for (int w = 0; w < MAX_WAYS; w++) begin
			new_ranks[w] = rd_ranks_q[w];
			if (w < int'(filled)) begin
				if (!(look_hit || full) || rd_ranks_q[w] < ref_rank)
					new_ranks[w] = rd_ranks_q[w] + RW'(1);
			end
		end
		new_ranks[victim] = '0;
		new_fill = (look_hit || full) ? filled : filled + CW'(1);
	end

	// memory port: read at accept, write back at resolve
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_tags_q  <= tag_mem[set_d];
			rd_ranks_q <= rank_mem[set_d];
			rd_fill_q  <= fill_mem[set_d];
			set_s1     <= set_d;
			tag_s1     <= tag_d;
			modify_s1  <= (kind == KIND_MODIFY);
		end
		if (cmd.resolve) begin
			tag_mem[set_s1]  <= new_tags;
			rank_mem[set_s1] <= new_ranks;
			fill_mem[set_s1] <= new_fill;
		end
	end

	// per-set valid bits stand in for the cleared fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			set_valid_q <= '0;
		else if (cmd.resolve)
			set_valid_q[set_s1] <= 1'b1;
	end

	// counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			evict_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.resolve) begin
				if (look_hit)
					hit_cnt_q <= hit_cnt_q + CNT_W'(1);
				else
					miss_cnt_q <= miss_cnt_q + CNT_W'(1);
				if (!look_hit && full)
					evict_cnt_q <= evict_cnt_q + CNT_W'(1);
			end else if (cmd.second) begin
				hit_cnt_q <= hit_cnt_q + CNT_W'(1);
			end
			if (cmd.resolve || cmd.second)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	logic [SET_INDEX_W-1:0] set_out;
	always_comb begin
		for (int i = 0; i < SET_INDEX_W; i++)
			set_out[i] = (i < SW) ? set_s1[i % SW] : 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.resolve) begin
			hit            <= look_hit;
			evicted        <= !look_hit && full;
			set_index      <= set_out;
			hit_total      <= look_hit ? hit_cnt_q + CNT_W'(1) : hit_cnt_q;
			miss_total     <= look_hit ? miss_cnt_q : miss_cnt_q + CNT_W'(1);
			eviction_total <= (!look_hit && full) ? evict_cnt_q + CNT_W'(1) : evict_cnt_q;
			last           <= !modify_s1;
		end else if (cmd.second) begin
			hit            <= 1'b1;
			evicted        <= 1'b0;
			hit_total      <= hit_cnt_q + CNT_W'(1);
			miss_total     <= miss_cnt_q;
			eviction_total <= evict_cnt_q;
			last           <= 1'b1;
		end
	end

	assign out_valid      = out_valid_q;
	assign stat.out_free  = !out_valid_q || out_ready;
	assign stat.is_modify = modify_s1;
	assign stat.no_access = (kind == KIND_NONE);

endmodule

/* src/set_assoc_lru_cache_sim_unit.sv */
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim_unit
// Set-associative cache simulator with LRU replacement and hit/miss counters.
// ----------------------------------------------------------------------------
// Usage:
//  - Program set_bits (0x0), offset_bits (0x4) and ways_in_use (0x8) over the
//    APB port while idle. Reads return the register values.
//  - Each input transaction (kind, address) is taken on in_valid & in_ready.
//    Load and store give one result; modify gives two, the second a hit.
//    Kind 3 is taken and dropped with no result.
//  - The set row is read from memory at accept; the lookup, LRU update
//    and write back follow in the resolve step once the output register
//    is free, which loads the result register. One access at a time:
//    the sequencer takes new input only while idle.
//  - Results sit in an output register until out_ready; while it is held
//    the sequencer waits before the next update. last marks the final
//    result of a transaction.
//  - Reset clears counters and per-set valid bits, resets configuration; no
//    memory clearing pass is needed, the block is ready right away.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim_unit #(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8,
	parameter int ADDR_WIDTH   = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [salc_pkg::PADDR_W-1:0]      paddr,
	input  logic [salc_pkg::PDATA_W-1:0]      pwdata,
	output logic [salc_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        kind,
	input  logic [ADDR_WIDTH-1:0]             address,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              hit,
	output logic                              evicted,
	output logic [salc_pkg::SET_INDEX_W-1:0]  set_index,
	output logic [salc_pkg::CNT_W-1:0]        hit_total,
	output logic [salc_pkg::CNT_W-1:0]        miss_total,
	output logic [salc_pkg::CNT_W-1:0]        eviction_total,
	output logic                              last
);
	import salc_pkg::*;

	logic [2:0] set_bits_q;
	logic [4:0] offset_bits_q;
	logic [3:0] ways_q;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q    <= 3'd0;
			offset_bits_q <= 5'd0;
			ways_q        <= 4'd1;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_SET_BITS:    set_bits_q    <= pwdata[2:0];
				REG_OFFSET_BITS: offset_bits_q <= pwdata[4:0];
				REG_WAYS:        ways_q        <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (reg_idx)
			REG_SET_BITS:    prdata = PDATA_W'(set_bits_q);
			REG_OFFSET_BITS: prdata = PDATA_W'(offset_bits_q);
			REG_WAYS:        prdata = PDATA_W'(ways_q);
			default:         prdata = '0;
		endcase
	end

	salc_cmd_t  cmd;
	salc_stat_t stat;

	salc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	salc_dp #(
		.MAX_SET_BITS (MAX_SET_BITS),
		.MAX_WAYS     (MAX_WAYS),
		.ADDR_WIDTH   (ADDR_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.set_bits       (set_bits_q),
		.offset_bits    (offset_bits_q),
		.ways_in_use    (ways_q),
		.kind           (kind),
		.address        (address),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.hit            (hit),
		.evicted        (evicted),
		.set_index      (set_index),
		.hit_total      (hit_total),
		.miss_total     (miss_total),
		.eviction_total (eviction_total),
		.last           (last)
	);

	// an eviction only happens on a miss
	a_evict_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && evicted))
		else $error("eviction reported together with a hit");

	// an access transaction blocks further input while it is resolved
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && kind != KIND_NONE) |=> !in_ready)
		else $error("input accepted while an access is in flight");

	// a non-final result is directly followed by the forced hit of a modify
	a_modify_second: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last) |=> (out_valid && last))
		else $error("modify second access skipped");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the set-associative LRU cache simulator. A model of
// the cache predicts hit, eviction, set index and running counters for every
// access; results are compared in order under random handshake idling.
// ----------------------------------------------------------------------------

// one expected result of a cache access
typedef struct packed {
	logic        hit;
	logic        evicted;
	logic [5:0]  set_index;
	logic [31:0] hit_total;
	logic [31:0] miss_total;
	logic [31:0] eviction_total;
	logic        last;
} access_result_t;

class lru_scoreboard;
	logic [31:0] tags[64][8];
	logic [2:0]  rank[64][8];
	int          filled[64];
	logic [31:0] hits, misses, evictions;
	int          set_bits_q, offset_bits_q, ways_q;
	access_result_t pending[$];
	int          mismatches;

	function new();
		for (int s = 0; s < 64; s++) filled[s] = 0;
		hits = 0; misses = 0; evictions = 0;
		set_bits_q = 0; offset_bits_q = 0; ways_q = 1;
		mismatches = 0;
	endfunction

	function void set_reg(logic [1:0] idx, logic [31:0] val);
		if (idx == salc_pkg::REG_SET_BITS) set_bits_q = val[2:0];
		else if (idx == salc_pkg::REG_OFFSET_BITS) offset_bits_q = val[4:0];
		else if (idx == salc_pkg::REG_WAYS) ways_q = val[3:0];
	endfunction

	// one cache lookup with LRU update
	function void lookup(logic [31:0] addr, logic is_last);
		int s, b, w, st, f, v;
		logic [31:0] tg, sh;
		logic h, ev;
		logic [2:0] r, worst;
		access_result_t res;
		s = set_bits_q > 6 ? 6 : set_bits_q;
		b = offset_bits_q;
		w = ways_q == 0 ? 1 : (ways_q > 8 ? 8 : ways_q);
		sh = addr >> b;
		st = s == 0 ? 0 : int'(sh & ((32'd1 << s) - 1));
		tg = (s + b >= 32) ? 32'd0 : addr >> (s + b);
		f = filled[st];
		h = 0; ev = 0; v = 0;
		for (int i = 0; i < f; i++)
			if (!h && tags[st][i] == tg) begin
				h = 1; v = i;
			end
		if (h) begin
			r = rank[st][v];
			for (int i = 0; i < f; i++) if (rank[st][i] < r) rank[st][i]++;
			rank[st][v] = 0;
			hits++;
		end else begin
			misses++;
			if (f >= w) begin
				worst = 0;
				for (int i = 0; i < f; i++)
					if (rank[st][i] >= worst) begin
						worst = rank[st][i]; v = i;
					end
				for (int i = 0; i < f; i++) if (rank[st][i] < worst) rank[st][i]++;
				ev = 1;
				evictions++;
			end else begin
				for (int i = 0; i < f; i++) rank[st][i]++;
				v = f;
				filled[st] = f + 1;
			end
			tags[st][v] = tg;
			rank[st][v] = 0;
		end
		res.hit = h; res.evicted = ev; res.set_index = st[5:0];
		res.hit_total = hits; res.miss_total = misses;
		res.eviction_total = evictions; res.last = is_last;
		pending.push_back(res);
	endfunction

	function void note_access(logic [1:0] k, logic [31:0] addr);
		if (k == salc_pkg::KIND_LOAD || k == salc_pkg::KIND_STORE)
			lookup(addr, 1'b1);
		else if (k == salc_pkg::KIND_MODIFY) begin
			lookup(addr, 1'b0);
			lookup(addr, 1'b1);
		end
	endfunction

	function void check_result(access_result_t got);
		access_result_t exp;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result at %0t", $time);
			return;
		end
		exp = pending.pop_front();
		if (got !== exp) begin
			mismatches++;
			if (mismatches <= 10)
				$display({"mismatch at %0t: exp h%0b e%0b s%0d %0d/%0d/%0d l%0b,",
					" got h%0b e%0b s%0d %0d/%0d/%0d l%0b"},
					$time, exp.hit, exp.evicted, exp.set_index, exp.hit_total,
					exp.miss_total, exp.eviction_total, exp.last,
					got.hit, got.evicted, got.set_index, got.hit_total,
					got.miss_total, got.eviction_total, got.last);
		end
	endfunction
endclass

module tb_top;
	import salc_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 0, in_ready;
	logic [1:0] kind = '0;
	logic [31:0] address = '0;
	logic out_valid, out_ready = 0;
	logic hit, evicted, last;
	logic [5:0] set_index;
	logic [31:0] hit_total, miss_total, eviction_total;

	int send_idle_pct = 0, recv_idle_pct = 0;
	bit recv_hold = 0;
	lru_scoreboard cache_sb;

	set_assoc_lru_cache_sim_unit dut (.*);

	always #10 clk = ~clk;

	initial begin
		#50_000_000;
		$display("Some tests failed");
		$finish;
	end

	// receiver: random backpressure, compare on each transaction
	always @(posedge clk) begin
		access_result_t got;
		if (arst_n && out_valid && out_ready) begin
			got.hit = hit; got.evicted = evicted; got.set_index = set_index;
			got.hit_total = hit_total; got.miss_total = miss_total;
			got.eviction_total = eviction_total; got.last = last;
			cache_sb.check_result(got);
		end
		out_ready <= arst_n && !recv_hold && ($urandom_range(99) >= recv_idle_pct);
	end

	// setup cycle, access cycle
	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		cache_sb.set_reg(idx, val);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	// valid drops at the accepting edge and rises again no earlier than the next
	task automatic send_access(logic [1:0] k, logic [31:0] a);
		@(posedge clk);
		while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		in_valid <= 1; kind <= k; address <= a;
		do @(posedge clk); while (!in_ready);
		cache_sb.note_access(k, a);
		in_valid <= 0;
	endtask

	// wait for all results, then let the block settle before a register write
	task automatic drain();
		int n = 0;
		while (cache_sb.pending.size() != 0 && n < 100000) begin
			@(posedge clk); n++;
		end
		repeat (10) @(posedge clk);
	endtask

	task automatic configure(int sb, int ob, int w);
		drain();
		write_reg(REG_SET_BITS, sb);
		write_reg(REG_OFFSET_BITS, ob);
		write_reg(REG_WAYS, w);
	endtask

	// mostly addresses from a small pool so sets fill, hit and evict
	task automatic random_phase(int count);
		logic [31:0] pool[16];
		logic [31:0] a;
		logic [1:0] k;
		for (int i = 0; i < 16; i++) pool[i] = $urandom();
		for (int i = 0; i < count; i++) begin
			a = ($urandom_range(3) == 0) ? $urandom() : pool[$urandom_range(15)];
			k = $urandom_range(9) == 0 ? KIND_NONE : 2'($urandom_range(2));
			send_access(k, a);
		end
	endtask

	initial begin
		cache_sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset config, extremes, every kind
		send_access(KIND_LOAD, 32'h0);
		send_access(KIND_LOAD, 32'h0);
		send_access(KIND_STORE, 32'hFFFF_FFFF);
		send_access(KIND_MODIFY, 32'h1234_5678);
		send_access(KIND_NONE, 32'hDEAD_BEEF);
		configure(6, 31, 8);  // wide shift: tag zero
		send_access(KIND_LOAD, 32'hFFFF_FFFF);
		send_access(KIND_LOAD, 32'h7FFF_FFFF);
		configure(7, 0, 0);   // set bits clamp, ways zero acts as one
		send_access(KIND_LOAD, 32'h0000_003F);
		send_access(KIND_STORE, 32'h0000_013F);
		send_access(KIND_MODIFY, 32'h0000_003F);
		configure(6, 2, 15);  // ways clamp to eight
		for (int i = 0; i < 10; i++) send_access(KIND_LOAD, i << 8);
		configure(6, 2, 2);   // ways lowered on a full set
		send_access(KIND_LOAD, 32'h0000_0F00);
		send_access(KIND_LOAD, 32'h0000_0000);

		// long receiver hold while sender keeps offering
		fork
			begin
				recv_hold = 1;
				repeat (300) @(posedge clk);
				recv_hold = 0;
			end
			for (int i = 0; i < 20; i++) send_access(KIND_MODIFY, i);
		join

		send_idle_pct = 32; recv_idle_pct = 64;
		configure(2, 4, 4);
		random_phase(350);
		configure(0, 0, 1);
		random_phase(300);
		send_idle_pct = 64; recv_idle_pct = 32;
		configure(3, 6, 8);
		random_phase(350);
		configure(1, 28, 3);
		random_phase(300);
		send_idle_pct = 0; recv_idle_pct = 0;
		configure(6, 0, 2);
		random_phase(350);
		configure(4, 3, 6);
		random_phase(350);

		drain();
		if (cache_sb.mismatches == 0 && cache_sb.pending.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

/* sim.f */
src/salc_pkg.sv
src/salc_ctrl.sv
src/salc_dp.sv
src/set_assoc_lru_cache_sim_unit.sv
verif/tb_top.sv
